[hw/rtl/fmss_pkg.sv]
// Package of the floor-marked search stack: field widths, operation codes,
// command and state types shared by the cell, the chain and the top level.
// Depends on nothing.
package fmss_pkg;

   localparam int STACK_DEPTH_DEF = 256;
   localparam int VALUE_WIDTH_DEF = 16;

   localparam int FUNC_W  = 2;
   localparam int VALUE_W = 16;
   localparam int COUNT_W = 9;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_NEGATE = 2'd2,
      FUNC_QUERY  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_DEEPER,
      CELL_SHALLOWER,
      CELL_NEGATE
   } cell_cmd_type;

   typedef enum logic [2:0] {
      CHAIN_HOLD,
      CHAIN_PUSH,
      CHAIN_POP,
      CHAIN_NEGATE,
      CHAIN_ROTATE
   } chain_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

[hw/rtl/floor_marked_search_stack_top.sv]
// Top level of the floor-marked search stack: control, counters, floor query scan
// and result register. Depends on fmss_pkg and fmss_chain.
//
// Each request beat carries one operation: push, pop, negate top, or floor query.
// Each request gives exactly one response beat with top value, size, empty flag,
// floor count, floor start, floor state count and error flag.
// Push, pop and negate complete at acceptance; the response is registered and
// appears in the next cycle, so they sustain one beat per cycle when the receiver
// is ready. A floor query rotates the whole cell chain once, one cell per cycle,
// and reads the entry leaving the deep end: its response is registered after the
// rotation, once the response register is free, and no request is taken meanwhile.
// A request is taken only when the response register is empty or being drained
// in the same cycle; while the receiver stalls, the response holds and req_ready
// stays low.
// Reset empties the stack and the response register; entry contents are not
// cleared, since only pushed entries are ever read.
module floor_marked_search_stack_top import fmss_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic signed [VALUE_W-1:0] req_push_value,
   input  logic [COUNT_W-1:0]        req_floor_number,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_top_value,
   output logic [COUNT_W-1:0]        rsp_stack_size,
   output logic                      rsp_is_empty,
   output logic [COUNT_W-1:0]        rsp_floors_total,
   output logic [COUNT_W-1:0]        rsp_floor_start,
   output logic [COUNT_W-1:0]        rsp_floor_states,
   output logic                      rsp_error_flag
);

   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;

   state_type state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   neg_ff, neg_in;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]   seen_ff, seen_in;
   logic [CNT_W-1:0]   run_ff, run_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   fstart_ff, fstart_in;
   logic [CNT_W-1:0]   fstates_ff, fstates_in;
   logic [COUNT_W-1:0] floor_ff, floor_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]    rsp_top_ff, rsp_top_in;
   logic [CNT_W-1:0]          rsp_size_ff, rsp_size_in;
   logic [CNT_W:0]            rsp_floors_ff, rsp_floors_in;
   logic [CNT_W-1:0]          rsp_fstart_ff, rsp_fstart_in;
   logic [CNT_W-1:0]          rsp_fstates_ff, rsp_fstates_in;
   logic                      rsp_error_ff, rsp_error_in;

   chain_cmd_type          chain_cmd;
   logic [VALUE_WIDTH-1:0] top_value;
   logic [VALUE_WIDTH-1:0] tail_value;
   logic [VALUE_WIDTH-1:0] push_value;
   logic [VALUE_WIDTH-1:0] neg_top;
   logic signed [31:0]     push_wide;
   logic                   out_free;
   logic                   req_accept;
   logic                   scan_last;
   logic                   stack_full;
   logic                   stack_empty;
   logic [CNT_W:0]         scan_sum;
   logic                   entry_live;
   logic [CNT_W-1:0]       entry_pos;
   logic [CMP_W-1:0]       seen_next;
   logic [CMP_W-1:0]       floor_wide;

   fmss_chain #(
      .STACK_DEPTH(STACK_DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_chain (
      .clock     (clock),
      .cmd       (chain_cmd),
      .push_value(push_value),
      .top_value (top_value),
      .tail_value(tail_value)
   );

   assign push_wide   = 32'(req_push_value);
   assign push_value  = push_wide[VALUE_WIDTH-1:0];
   assign neg_top     = (~top_value) + 1'b1;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_accept  = req_valid && req_ready;
   assign scan_last   = scan_idx_ff == IDX_W'(STACK_DEPTH - 1);
   assign stack_full  = fill_ff == CNT_W'(STACK_DEPTH);
   assign stack_empty = fill_ff == '0;

   assign scan_sum   = (CNT_W+1)'(scan_idx_ff) + (CNT_W+1)'(fill_ff);
   assign entry_live = scan_sum >= (CNT_W+1)'(STACK_DEPTH);
   assign entry_pos  = CNT_W'(scan_sum - (CNT_W+1)'(STACK_DEPTH));
   assign seen_next  = CMP_W'(seen_ff) + 1'b1;
   assign floor_wide = CMP_W'(floor_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_func == FUNC_QUERY) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_ready = 1'b0;
      chain_cmd = CHAIN_HOLD;
      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (req_accept) begin
               case (req_func)
                  FUNC_PUSH:   chain_cmd = stack_full ? CHAIN_HOLD : CHAIN_PUSH;
                  FUNC_POP:    chain_cmd = stack_empty ? CHAIN_HOLD : CHAIN_POP;
                  FUNC_NEGATE: chain_cmd = stack_empty ? CHAIN_HOLD : CHAIN_NEGATE;
                  default:     chain_cmd = CHAIN_HOLD;
               endcase
            end
         end
         ST_SCAN: chain_cmd = CHAIN_ROTATE;
         ST_DONE: chain_cmd = CHAIN_HOLD;
         default: chain_cmd = CHAIN_HOLD;
      endcase
   end

   // Counters, query scan and response register.
   always_comb begin
      fill_in        = fill_ff;
      neg_in         = neg_ff;
      scan_idx_in    = scan_idx_ff;
      seen_in        = seen_ff;
      run_in         = run_ff;
      done_in        = done_ff;
      fstart_in      = fstart_ff;
      fstates_in     = fstates_ff;
      floor_in       = floor_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_top_in     = rsp_top_ff;
      rsp_size_in    = rsp_size_ff;
      rsp_floors_in  = rsp_floors_ff;
      rsp_fstart_in  = rsp_fstart_ff;
      rsp_fstates_in = rsp_fstates_ff;
      rsp_error_in   = rsp_error_ff;

      if (state_ff == ST_IDLE && req_accept && req_func != FUNC_QUERY) begin
         rsp_valid_in   = 1'b1;
         rsp_fstart_in  = '0;
         rsp_fstates_in = '0;
         rsp_error_in   = 1'b0;
         rsp_top_in     = stack_empty ? '0 : top_value;
         case (req_func)
            FUNC_PUSH: begin
               if (stack_full) begin
                  rsp_error_in = 1'b1;
               end else begin
                  fill_in    = fill_ff + 1'b1;
                  neg_in     = neg_ff + CNT_W'(push_value[VALUE_WIDTH-1]);
                  rsp_top_in = push_value;
               end
            end
            FUNC_POP: begin
               if (stack_empty) begin
                  rsp_error_in = 1'b1;
               end else begin
                  fill_in = fill_ff - 1'b1;
                  neg_in  = neg_ff - CNT_W'(top_value[VALUE_WIDTH-1]);
               end
            end
            FUNC_NEGATE: begin
               if (stack_empty) begin
                  rsp_error_in = 1'b1;
               end else begin
                  neg_in = neg_ff - CNT_W'(top_value[VALUE_WIDTH-1])
                         + CNT_W'(neg_top[VALUE_WIDTH-1]);
                  rsp_top_in = neg_top;
               end
            end
            default: rsp_error_in = 1'b0;
         endcase
         rsp_size_in   = fill_in;
         rsp_floors_in = (CNT_W+1)'(neg_in) + 1'b1;
      end

      if (state_ff == ST_IDLE && req_accept && req_func == FUNC_QUERY) begin
         scan_idx_in = '0;
         seen_in     = '0;
         run_in      = '0;
         done_in     = 1'b0;
         fstart_in   = '0;
         fstates_in  = '0;
         floor_in    = req_floor_number;
      end

      if (state_ff == ST_SCAN) begin
         scan_idx_in = scan_idx_ff + 1'b1;
         if (entry_live) begin
            if (tail_value[VALUE_WIDTH-1]) begin
               seen_in = seen_ff + 1'b1;
               run_in  = '0;
               if (floor_ff >= COUNT_W'(2) && seen_next + 1'b1 == floor_wide) begin
                  fstart_in = entry_pos + 1'b1;
               end
               if (!done_ff && seen_next == floor_wide) begin
                  fstates_in = run_ff;
                  done_in    = 1'b1;
               end
            end else begin
               run_in = run_ff + 1'b1;
            end
         end
      end

      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_top_in     = stack_empty ? '0 : top_value;
         rsp_size_in    = fill_ff;
         rsp_floors_in  = (CNT_W+1)'(neg_ff) + 1'b1;
         rsp_fstart_in  = fstart_ff;
         rsp_fstates_in = done_ff ? fstates_ff : run_ff;
         rsp_error_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         neg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff    <= scan_idx_in;
      seen_ff        <= seen_in;
      run_ff         <= run_in;
      done_ff        <= done_in;
      fstart_ff      <= fstart_in;
      fstates_ff     <= fstates_in;
      floor_ff       <= floor_in;
      rsp_top_ff     <= rsp_top_in;
      rsp_size_ff    <= rsp_size_in;
      rsp_floors_ff  <= rsp_floors_in;
      rsp_fstart_ff  <= rsp_fstart_in;
      rsp_fstates_ff <= rsp_fstates_in;
      rsp_error_ff   <= rsp_error_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_top_value    = VALUE_W'(rsp_top_ff);
   assign rsp_stack_size   = COUNT_W'(rsp_size_ff);
   assign rsp_is_empty     = rsp_size_ff == '0;
   assign rsp_floors_total = COUNT_W'(rsp_floors_ff);
   assign rsp_floor_start  = COUNT_W'(rsp_fstart_ff);
   assign rsp_floor_states = COUNT_W'(rsp_fstates_ff);
   assign rsp_error_flag   = rsp_error_ff;

   a_neg_within_fill: assert property (@(posedge clock) disable iff (reset)
      neg_ff <= fill_ff)
      else $error("Negative entry count exceeds the fill count.");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(STACK_DEPTH))
      else $error("Fill count exceeds the stack depth.");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_func == FUNC_POP && !stack_empty
      |=> fill_ff == $past(fill_ff) - 1'b1)
      else $error("Accepted pop did not shrink the stack by one.");

   a_query_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |=> $stable(fill_ff) && $stable(neg_ff))
      else $error("Stack counters changed during a floor scan.");

endmodule

[hw/rtl/fmss_cell.sv]
// One stack cell: holds a single entry and takes its neighbor's entry on a shift.
// Depends on fmss_pkg.
module fmss_cell import fmss_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  cell_cmd_type           cmd,
   input  logic [VALUE_WIDTH-1:0] from_shallow,
   input  logic [VALUE_WIDTH-1:0] from_deep,
   output logic [VALUE_WIDTH-1:0] value
);

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;

   always_comb begin
      case (cmd)
         CELL_HOLD:      value_in = value_ff;
         CELL_DEEPER:    value_in = from_shallow;
         CELL_SHALLOWER: value_in = from_deep;
         CELL_NEGATE:    value_in = (~value_ff) + 1'b1;
         default:        value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[hw/rtl/fmss_chain.sv]
// Row of stack cells with the top entry in cell 0; push, pop, negate and rotate.
// Depends on fmss_pkg and fmss_cell.
module fmss_chain import fmss_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  chain_cmd_type          cmd,
   input  logic [VALUE_WIDTH-1:0] push_value,
   output logic [VALUE_WIDTH-1:0] top_value,
   output logic [VALUE_WIDTH-1:0] tail_value
);

   logic [VALUE_WIDTH-1:0] cell_value [STACK_DEPTH];
   logic [VALUE_WIDTH-1:0] head_input;
   cell_cmd_type           head_cmd;
   cell_cmd_type           body_cmd;

   always_comb begin
      case (cmd)
         CHAIN_HOLD: begin
            head_cmd = CELL_HOLD;
            body_cmd = CELL_HOLD;
         end
         CHAIN_PUSH, CHAIN_ROTATE: begin
            head_cmd = CELL_DEEPER;
            body_cmd = CELL_DEEPER;
         end
         CHAIN_POP: begin
            head_cmd = CELL_SHALLOWER;
            body_cmd = CELL_SHALLOWER;
         end
         CHAIN_NEGATE: begin
            head_cmd = CELL_NEGATE;
            body_cmd = CELL_HOLD;
         end
         default: begin
            head_cmd = CELL_HOLD;
            body_cmd = CELL_HOLD;
         end
      endcase
   end

   assign head_input = (cmd == CHAIN_ROTATE) ? cell_value[STACK_DEPTH-1] : push_value;

   fmss_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_head (
      .clock       (clock),
      .cmd         (head_cmd),
      .from_shallow(head_input),
      .from_deep   (cell_value[1]),
      .value       (cell_value[0])
   );

   for (genvar i = 1; i < STACK_DEPTH; i++) begin : g_body
      fmss_cell #(
         .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
         .clock       (clock),
         .cmd         (body_cmd),
         .from_shallow(cell_value[i-1]),
         .from_deep   (cell_value[(i == STACK_DEPTH-1) ? i : i+1]),
         .value       (cell_value[i])
      );
   end

   assign top_value  = cell_value[0];
   assign tail_value = cell_value[STACK_DEPTH-1];

endmodule

[verif/tb_top.sv]
// Self-checking testbench for floor_marked_search_stack_top: a queue-fed driver, a monitor
// holding its own stack and floor-scan predictor, random idling and one long receiver stall.
// Depends on fmss_pkg and the floor_marked_search_stack_top RTL.
module tb_top import fmss_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = STACK_DEPTH_DEF;
   localparam int TOTAL_ITEMS  = 1125;
   localparam int IDLE_PCT     = 22;
   localparam int HOLD_START   = 3000;
   localparam int HOLD_CYCLES  = 400;
   localparam int CALM_START   = 6000;
   localparam int CALM_END     = 9000;
   localparam int DRAIN_CYCLES = DEPTH + 40;
   localparam int TIMEOUT_NS   = 10_000_000;

   typedef struct {
      func_type                  func;
      logic signed [VALUE_W-1:0] push_value;
      logic [COUNT_W-1:0]        floor_number;
   } stack_op_type;

   typedef struct {
      logic signed [VALUE_W-1:0] top_value;
      logic [COUNT_W-1:0]        stack_size;
      logic                      is_empty;
      logic [COUNT_W-1:0]        floors_total;
      logic [COUNT_W-1:0]        floor_start;
      logic [COUNT_W-1:0]        floor_states;
      logic                      error_flag;
   } stack_rsp_type;

   typedef enum {MODE_CLIMB, MODE_DESCEND, MODE_MIXED} walk_mode_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [FUNC_W-1:0]         req_func = '0;
   logic signed [VALUE_W-1:0] req_push_value = '0;
   logic [COUNT_W-1:0]        req_floor_number = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_top_value;
   logic [COUNT_W-1:0]        rsp_stack_size;
   logic                      rsp_is_empty;
   logic [COUNT_W-1:0]        rsp_floors_total;
   logic [COUNT_W-1:0]        rsp_floor_start;
   logic [COUNT_W-1:0]        rsp_floor_states;
   logic                      rsp_error_flag;

   stack_op_type  pending_ops[$];
   stack_rsp_type expected_results[$];
   logic          req_taken = 1'b0;
   int            error_count = 0;
   int            gen_size = 0;
   int            send_cycle = 0;
   int            recv_cycle = 0;

   logic signed [VALUE_W-1:0] model_entries [DEPTH];
   int                        model_fill = 0;
   int                        model_negatives = 0;

   floor_marked_search_stack_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_push_value   (req_push_value),
      .req_floor_number (req_floor_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_top_value    (rsp_top_value),
      .rsp_stack_size   (rsp_stack_size),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_floors_total (rsp_floors_total),
      .rsp_floor_start  (rsp_floor_start),
      .rsp_floor_states (rsp_floor_states),
      .rsp_error_flag   (rsp_error_flag)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic stack_rsp_type predict_stack_op(stack_op_type op);
      stack_rsp_type r;
      logic signed [VALUE_W-1:0] old_v;
      logic signed [VALUE_W-1:0] new_v;
      int seen;
      int run;
      bit done;
      bit popped;
      r = '{default: '0};
      seen = 0;
      run = 0;
      done = 0;
      popped = 0;
      case (op.func)
         FUNC_PUSH: begin
            if (model_fill >= DEPTH) begin
               r.error_flag = 1'b1;
            end else begin
               model_entries[model_fill] = op.push_value;
               model_fill++;
               if (op.push_value < 0) model_negatives++;
            end
         end
         FUNC_POP: begin
            if (model_fill == 0) begin
               r.error_flag = 1'b1;
            end else begin
               model_fill--;
               r.top_value = model_entries[model_fill];
               popped = 1;
               if (r.top_value < 0) model_negatives--;
            end
         end
         FUNC_NEGATE: begin
            if (model_fill == 0) begin
               r.error_flag = 1'b1;
            end else begin
               old_v = model_entries[model_fill-1];
               new_v = -old_v;
               if (old_v < 0) model_negatives--;
               if (new_v < 0) model_negatives++;
               model_entries[model_fill-1] = new_v;
            end
         end
         default: begin
            for (int i = 0; i < model_fill; i++) begin
               if (model_entries[i] < 0) begin
                  seen++;
                  if (op.floor_number >= 2 && seen == op.floor_number - 1)
                     r.floor_start = COUNT_W'(i + 1);
                  if (!done && seen == op.floor_number) begin
                     r.floor_states = COUNT_W'(run);
                     done = 1;
                  end
                  run = 0;
               end else begin
                  run++;
               end
            end
            if (!done) r.floor_states = COUNT_W'(run);
         end
      endcase
      if (!popped && model_fill > 0) r.top_value = model_entries[model_fill-1];
      r.stack_size   = COUNT_W'(model_fill);
      r.is_empty     = (model_fill == 0);
      r.floors_total = COUNT_W'(model_negatives + 1);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic signed [31:0] got_v,
                                  logic signed [31:0] want_v);
      $display("mismatch at %0t ns: %s got %0d, wanted %0d", $realtime, what, got_v, want_v);
      error_count++;
   endtask

   task automatic check_response(stack_rsp_type got);
      stack_rsp_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("response beat with nothing pending, top_value", got.top_value, 0);
         return;
      end
      want = expected_results.pop_front();
      if (got.top_value !== want.top_value)
         report_mismatch("top_value", got.top_value, want.top_value);
      if (got.stack_size !== want.stack_size)
         report_mismatch("stack_size", got.stack_size, want.stack_size);
      if (got.is_empty !== want.is_empty)
         report_mismatch("is_empty", got.is_empty, want.is_empty);
      if (got.floors_total !== want.floors_total)
         report_mismatch("floors_total", got.floors_total, want.floors_total);
      if (got.floor_start !== want.floor_start)
         report_mismatch("floor_start", got.floor_start, want.floor_start);
      if (got.floor_states !== want.floor_states)
         report_mismatch("floor_states", got.floor_states, want.floor_states);
      if (got.error_flag !== want.error_flag)
         report_mismatch("error_flag", got.error_flag, want.error_flag);
   endtask

   function automatic bit take_idle(int cyc);
      if (cyc >= CALM_START && cyc < CALM_END) return 1'b0;
      return $urandom_range(0, 99) < IDLE_PCT;
   endfunction

   task automatic add_op(func_type f, logic [VALUE_W-1:0] value, int floor_no);
      stack_op_type op;
      op.func         = f;
      op.push_value   = value;
      op.floor_number = COUNT_W'(floor_no);
      pending_ops     = {pending_ops, op};
      if (f == FUNC_PUSH && gen_size < DEPTH) gen_size++;
      if (f == FUNC_POP && gen_size > 0) gen_size--;
   endtask

   function automatic logic [VALUE_W-1:0] rand_value();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            3: return 16'h8000;
            default: return 16'h0001;
         endcase
      end
      if (pick <= 3) return VALUE_W'($urandom_range(32768, 65535));
      return VALUE_W'($urandom_range(0, 32767));
   endfunction

   function automatic int rand_floor();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return $urandom_range(0, 4);
      if (pick < 8) return $urandom_range(0, 257);
      return $urandom_range(0, 511);
   endfunction

   function automatic func_type pick_func(walk_mode_type mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_CLIMB: begin
            if (roll < 75) return FUNC_PUSH;
            if (roll < 85) return FUNC_POP;
            if (roll < 93) return FUNC_NEGATE;
            return FUNC_QUERY;
         end
         MODE_DESCEND: begin
            if (roll < 15) return FUNC_PUSH;
            if (roll < 85) return FUNC_POP;
            if (roll < 93) return FUNC_NEGATE;
            return FUNC_QUERY;
         end
         default: begin
            if (roll < 35) return FUNC_PUSH;
            if (roll < 65) return FUNC_POP;
            if (roll < 90) return FUNC_NEGATE;
            return FUNC_QUERY;
         end
      endcase
   endfunction

   task automatic build_stimulus();
      int seg;
      int seg_len;
      walk_mode_type mode;
      // Underflow and queries on an empty stack.
      add_op(FUNC_POP, 16'h1234, 0);
      add_op(FUNC_NEGATE, 16'h0000, 0);
      add_op(FUNC_QUERY, 16'h0000, 1);
      add_op(FUNC_QUERY, 16'hFFFF, 0);
      // Value extremes, negation of the most negative value and of zero.
      add_op(FUNC_PUSH, 16'h7FFF, 511);
      add_op(FUNC_PUSH, 16'h0000, 0);
      add_op(FUNC_PUSH, 16'h8000, 0);
      add_op(FUNC_NEGATE, 16'h0000, 0);
      add_op(FUNC_PUSH, 16'h0003, 0);
      add_op(FUNC_PUSH, 16'hFFFF, 0);
      add_op(FUNC_PUSH, 16'h0000, 0);
      add_op(FUNC_NEGATE, 16'h0000, 0);
      // Floors inside, at the top and beyond the last one.
      add_op(FUNC_QUERY, 16'h0000, 1);
      add_op(FUNC_QUERY, 16'h0000, 2);
      add_op(FUNC_QUERY, 16'h0000, 3);
      add_op(FUNC_QUERY, 16'h0000, 4);
      add_op(FUNC_QUERY, 16'h0000, 0);
      add_op(FUNC_QUERY, 16'h0000, 511);
      add_op(FUNC_PUSH, 16'h0007, 0);
      add_op(FUNC_NEGATE, 16'h0000, 0);
      add_op(FUNC_NEGATE, 16'h0000, 0);
      add_op(FUNC_POP, 16'h0000, 0);
      add_op(FUNC_POP, 16'h0000, 0);
      add_op(FUNC_QUERY, 16'h0000, 257);

      seg = 0;
      while (pending_ops.size() < TOTAL_ITEMS) begin
         if (seg == 3) begin
            // Fill with opened states only, so every floor exists, then overflow.
            while (gen_size < DEPTH)
               add_op(FUNC_PUSH, VALUE_W'($urandom_range(32768, 65535)), 0);
            repeat (3) add_op(FUNC_PUSH, rand_value(), 0);
            add_op(FUNC_QUERY, 16'h0000, 1);
            add_op(FUNC_QUERY, 16'h0000, 2);
            add_op(FUNC_QUERY, 16'h0000, 256);
            add_op(FUNC_QUERY, 16'h0000, 257);
            add_op(FUNC_QUERY, 16'h0000, 258);
            add_op(FUNC_NEGATE, 16'h0000, 0);
            add_op(FUNC_QUERY, 16'h0000, $urandom_range(0, 511));
         end else if (seg == 4) begin
            while (gen_size > 0) begin
               if ($urandom_range(0, 19) == 0) add_op(FUNC_NEGATE, 16'h0000, 0);
               else add_op(FUNC_POP, 16'h0000, 0);
            end
            repeat (2) add_op(FUNC_POP, rand_value(), 0);
            add_op(FUNC_NEGATE, rand_value(), 0);
            add_op(FUNC_QUERY, rand_value(), rand_floor());
         end else begin
            mode = walk_mode_type'($urandom_range(0, 2));
            seg_len = $urandom_range(30, 150);
            repeat (seg_len) add_op(pick_func(mode), rand_value(), rand_floor());
         end
         seg++;
      end
   endtask

   always @(negedge clock) begin
      stack_op_type next_op;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         send_cycle++;
         if (!req_valid || req_taken) begin
            if (pending_ops.size() > 0 && !take_idle(send_cycle)) begin
               next_op = pending_ops.pop_front();
               req_valid        <= 1'b1;
               req_func         <= next_op.func;
               req_push_value   <= next_op.push_value;
               req_floor_number <= next_op.floor_number;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         recv_cycle++;
         if (recv_cycle >= HOLD_START && recv_cycle < HOLD_START + HOLD_CYCLES)
            rsp_ready <= 1'b0;
         else
            rsp_ready <= !take_idle(recv_cycle);
      end
   end

   always @(posedge clock) begin
      stack_op_type  seen_op;
      stack_rsp_type got;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            seen_op.func         = func_type'(req_func);
            seen_op.push_value   = req_push_value;
            seen_op.floor_number = req_floor_number;
            expected_results     = {expected_results, predict_stack_op(seen_op)};
         end
         if (rsp_valid && rsp_ready) begin
            got.top_value    = rsp_top_value;
            got.stack_size   = rsp_stack_size;
            got.is_empty     = rsp_is_empty;
            got.floors_total = rsp_floors_total;
            got.floor_start  = rsp_floor_start;
            got.floor_states = rsp_floor_states;
            got.error_flag   = rsp_error_flag;
            check_response(got);
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_ops.size() > 0 || req_valid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("status: fail");
      $finish;
   end

endmodule
